### hw/rtl/pscull_pkg.sv
// Shared types, codes and widths for the point-in-sphere cull table.
package pscull_pkg;

    localparam int MAX_PEAKS_DEFAULT = 64;

    localparam int COORD_W  = 24;
    localparam int RAD_W    = 24;
    localparam int FACTOR_W = 4;
    localparam int SCALED_W = RAD_W + FACTOR_W;
    localparam int LIMIT_W  = 2 * SCALED_W;
    localparam int MAG_W    = COORD_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam int INDEX_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [RAD_W-1:0]    NO_SHAPE_RADIUS_RST = RAD_W'(819);
    localparam logic [RAD_W-1:0]    DEFAULT_RADIUS_RST  = RAD_W'(410);
    localparam logic [FACTOR_W-1:0] RADIUS_FACTOR_RST   = FACTOR_W'(2);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TEST  = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        SHAPE_NONE      = 2'd0,
        SHAPE_SPHERE    = 2'd1,
        SHAPE_ELLIPSOID = 2'd2,
        SHAPE_UNUSED    = 2'd3
    } shape_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NO_SHAPE_RADIUS = 2'd0,
        CFG_DEFAULT_RADIUS  = 2'd1,
        CFG_RADIUS_FACTOR   = 2'd2,
        CFG_UNUSED          = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD_SQ,
        ST_LOAD_WR,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [1:0]                shape_kind;
        logic [RAD_W-1:0]          radius_a;
        logic [RAD_W-1:0]          radius_b;
        logic [RAD_W-1:0]          radius_c;
        logic                      radius_present;
    } item_t;

    typedef struct packed {
        logic               point_hit;
        logic [INDEX_W-1:0] hit_index;
        logic               load_ok;
        logic               table_full;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] centre_x;
        logic signed [COORD_W-1:0] centre_y;
        logic signed [COORD_W-1:0] centre_z;
        logic [LIMIT_W-1:0]        limit_squared;
    } entry_t;

endpackage

### hw/rtl/point_in_sphere_set_cull.sv
// Point-in-sphere cull table: peak store, load datapath and point scan.
//
// Items enter on item_valid/item_ready, one beat each, and each gives exactly
// one result beat on result_valid/result_ready. Configuration is a plain write
// port (cfg_we, cfg_index, cfg_data) taken on any edge with cfg_we high.
// The peak table lives in one synchronous memory, one entry per address.
// Path through the states from acceptance to the raised result_valid:
//   clear, unused command, load into a full table : DECODE, DONE
//   load                                          : DECODE, LOAD_SQ, LOAD_WR, DONE
//   test with N stored peaks                      : DECODE, SCAN, DONE (N = 0: no SCAN)
// A test reads one entry per cycle through the single read port, so the
// memory port sets the scan rate; the difference, square and compare stages
// behind it are pipelined. One item is worked on at a time; item_ready rises
// again in the cycle the result beat is first valid. Reset empties the table
// (count to zero, memory contents left as is) and loads the register
// defaults. If the receiver stalls, the result beat holds and a finished
// following item waits until the output register frees up.
module point_in_sphere_set_cull
    import pscull_pkg::*;
#(
    parameter int MAX_PEAKS = MAX_PEAKS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAD_W-1:0]     cfg_data
);

    localparam int ADDR_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_PEAKS);

    // configuration
    logic [RAD_W-1:0]    no_shape_radius_reg;
    logic [RAD_W-1:0]    default_radius_reg;
    logic [FACTOR_W-1:0] radius_factor_reg;

    // control
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              hit_found_reg, hit_found_next;
    logic [ADDR_W-1:0] hit_idx_reg, hit_idx_next;
    result_t           res_reg, res_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    // datapath
    item_t                item_reg;
    logic [SCALED_W-1:0]  scaled_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    // peak memory
    entry_t               peak_mem [MAX_PEAKS];
    entry_t               rd_data_reg;
    logic                 mem_we;
    logic                 issuing;
    logic                 issue_last;
    logic [ADDR_W-1:0]    rd_addr;
    entry_t               wr_data;

    // scan pipeline
    logic                 s1_valid_reg, s1_last_reg;
    logic [ADDR_W-1:0]    s1_idx_reg;
    logic                 s2_valid_reg, s2_last_reg;
    logic [ADDR_W-1:0]    s2_idx_reg;
    logic [MAG_W-1:0]     mag_x_reg, mag_y_reg, mag_z_reg;
    logic [LIMIT_W-1:0]   s2_limit_reg;
    logic                 s3_valid_reg, s3_last_reg;
    logic [ADDR_W-1:0]    s3_idx_reg;
    logic [SQ_W-1:0]      sq_x_reg, sq_y_reg, sq_z_reg;
    logic [LIMIT_W-1:0]   s3_limit_reg;

    logic [RAD_W-1:0]     radius_sel;
    logic [RAD_W-1:0]     radius_ab;
    logic [DIST_W-1:0]    dist_sum;
    logic                 s3_hit;
    logic                 slot_free;
    logic [COORD_W:0]     diff_x, diff_y, diff_z;
    logic [ADDR_W+INDEX_W-1:0] hit_idx_wide;
    logic [ADDR_W+INDEX_W-1:0] s3_idx_wide;

    function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W:0] d);
        logic [COORD_W:0] m;
        begin
            m = d[COORD_W] ? (~d + 1'b1) : d;
            abs_diff = m[MAG_W-1:0];
        end
    endfunction

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign slot_free    = !result_valid_reg || result_ready;

    assign issuing    = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign issue_last = (issue_reg == count_reg - CNT_W'(1));
    assign rd_addr    = issue_reg[ADDR_W-1:0];

    assign wr_data.centre_x      = item_reg.pos_x;
    assign wr_data.centre_y      = item_reg.pos_y;
    assign wr_data.centre_z      = item_reg.pos_z;
    assign wr_data.limit_squared = limit_reg;

    // radius pick for a load
    assign radius_ab = (item_reg.radius_b > item_reg.radius_a) ? item_reg.radius_b
                                                               : item_reg.radius_a;
    always_comb
    begin
        unique case (shape_t'(item_reg.shape_kind))
            SHAPE_SPHERE:
                radius_sel = item_reg.radius_present ? item_reg.radius_a
                                                     : default_radius_reg;
            SHAPE_ELLIPSOID:
                radius_sel = (item_reg.radius_c > radius_ab) ? item_reg.radius_c
                                                             : radius_ab;
            default:
                radius_sel = no_shape_radius_reg;
        endcase
    end

    assign diff_x = {item_reg.pos_x[COORD_W-1], item_reg.pos_x}
                  - {rd_data_reg.centre_x[COORD_W-1], rd_data_reg.centre_x};
    assign diff_y = {item_reg.pos_y[COORD_W-1], item_reg.pos_y}
                  - {rd_data_reg.centre_y[COORD_W-1], rd_data_reg.centre_y};
    assign diff_z = {item_reg.pos_z[COORD_W-1], item_reg.pos_z}
                  - {rd_data_reg.centre_z[COORD_W-1], rd_data_reg.centre_z};

    assign dist_sum = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);
    assign s3_hit   = (LIMIT_W'(dist_sum) <= s3_limit_reg);

    assign hit_idx_wide = {{INDEX_W{1'b0}}, hit_idx_reg};
    assign s3_idx_wide  = {{INDEX_W{1'b0}}, s3_idx_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_shape_radius_reg <= NO_SHAPE_RADIUS_RST;
            default_radius_reg  <= DEFAULT_RADIUS_RST;
            radius_factor_reg   <= RADIUS_FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NO_SHAPE_RADIUS: no_shape_radius_reg <= cfg_data;
                CFG_DEFAULT_RADIUS:  default_radius_reg  <= cfg_data;
                CFG_RADIUS_FACTOR:   radius_factor_reg   <= cfg_data[FACTOR_W-1:0];
                default:             ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            issue_reg        <= '0;
            hit_found_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            issue_reg        <= issue_next;
            hit_found_reg    <= hit_found_next;
            result_valid_reg <= result_valid_next;
            s1_valid_reg     <= issuing;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (state_reg == ST_DECODE)
            scaled_reg <= SCALED_W'(radius_sel) * SCALED_W'(radius_factor_reg);
        if (state_reg == ST_LOAD_SQ)
            limit_reg <= scaled_reg * scaled_reg;

        hit_idx_reg <= hit_idx_next;
        res_reg     <= res_next;
        result_reg  <= result_next;

        s1_idx_reg   <= rd_addr;
        s1_last_reg  <= issue_last;

        s2_idx_reg   <= s1_idx_reg;
        s2_last_reg  <= s1_last_reg;
        mag_x_reg    <= abs_diff(diff_x);
        mag_y_reg    <= abs_diff(diff_y);
        mag_z_reg    <= abs_diff(diff_z);
        s2_limit_reg <= rd_data_reg.limit_squared;

        s3_idx_reg   <= s2_idx_reg;
        s3_last_reg  <= s2_last_reg;
        sq_x_reg     <= mag_x_reg * mag_x_reg;
        sq_y_reg     <= mag_y_reg * mag_y_reg;
        sq_z_reg     <= mag_z_reg * mag_z_reg;
        s3_limit_reg <= s2_limit_reg;
    end

    // peak memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            peak_mem[count_reg[ADDR_W-1:0]] <= wr_data;
        if (issuing)
            rd_data_reg <= peak_mem[rd_addr];
    end

    // next state and outputs
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        issue_next        = issue_reg;
        hit_found_next    = hit_found_reg;
        hit_idx_next      = hit_idx_reg;
        res_next          = res_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        mem_we            = 1'b0;

        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                res_next   = '0;
                state_next = ST_DONE;
                unique case (command_t'(item_reg.command))
                    CMD_CLEAR:
                        count_next = '0;
                    CMD_LOAD:
                    begin
                        if (count_reg == COUNT_MAX)
                            res_next.table_full = 1'b1;
                        else
                            state_next = ST_LOAD_SQ;
                    end
                    CMD_TEST:
                    begin
                        if (count_reg != '0)
                        begin
                            issue_next     = '0;
                            hit_found_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            ST_LOAD_SQ:
                state_next = ST_LOAD_WR;
            ST_LOAD_WR:
            begin
                mem_we           = 1'b1;
                count_next       = count_reg + CNT_W'(1);
                res_next.load_ok = 1'b1;
                state_next       = ST_DONE;
            end
            ST_SCAN:
            begin
                if (issuing)
                    issue_next = issue_reg + CNT_W'(1);
                // keep the lowest matching index; entries leave in order
                if (s3_valid_reg && s3_hit && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = s3_idx_reg;
                end
                if (s3_valid_reg && s3_last_reg)
                begin
                    res_next = '0;
                    if (hit_found_reg)
                    begin
                        res_next.point_hit = 1'b1;
                        res_next.hit_index = hit_idx_wide[INDEX_W-1:0];
                    end
                    else if (s3_hit)
                    begin
                        res_next.point_hit = 1'b1;
                        res_next.hit_index = s3_idx_wide[INDEX_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    result_next       = res_reg;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
